// File: rtl/ecls_pkg.sv
// Shared types and constants for the edge candidate likelihood select block.
// No dependencies; every other file of the block depends on this package.
`default_nettype none

package ecls_pkg;

  localparam int CONV_W  = 24;
  localparam int THR_W   = 25;
  localparam int MU1_W   = 8;
  localparam int MU2_W   = 10;
  localparam int SCORE_W = 25;
  localparam int SQ_W    = 47;
  localparam int IDX_W   = 7;
  localparam int CODE_W  = 2;
  localparam int ADDR_W  = 4;
  localparam int DATA_W  = 32;

  // register indexes, taken from paddr[3:2]
  localparam logic [1:0] REG_MODE      = 2'd0;
  localparam logic [1:0] REG_THRESHOLD = 2'd1;
  localparam logic [1:0] REG_MU1       = 2'd2;
  localparam logic [1:0] REG_MU2       = 2'd3;

  // suppression codes
  localparam logic [CODE_W-1:0] SUP_NONE      = 2'd0;
  localparam logic [CODE_W-1:0] SUP_CONTRAST  = 2'd1;
  localparam logic [CODE_W-1:0] SUP_THRESHOLD = 2'd2;

  typedef struct packed {
    logic             contrast_mode;
    logic [THR_W-1:0] likelihood_threshold;
    logic [MU1_W-1:0] ratio_below;
    logic [MU2_W-1:0] ratio_above;
  } ecls_cfg_t;

  typedef struct packed {
    logic               take;       // candidate replaces the current best
    logic [SCORE_W-1:0] score;      // score stored when taken
    logic               nz_write;   // candidate passed the threshold in contrast mode
    logic               nz_value;   // candidate convolution is nonzero
    logic [SQ_W-1:0]    square;     // square of the candidate convolution
  } ecls_decision_t;

endpackage

`default_nettype wire

// File: rtl/ecls_if.sv
// Handshake channels of the block: candidate words in, result words out.
// Depends on ecls_pkg for field widths.
`default_nettype none

interface ecls_in_if;
  logic                               valid;
  logic                               ready;
  logic signed [ecls_pkg::CONV_W-1:0] conv_value;
  logic signed [ecls_pkg::CONV_W-1:0] reference_conv;
  logic                               scan_last;

  modport source (output valid, output conv_value, output reference_conv,
                  output scan_last, input ready);
  modport sink   (input valid, input conv_value, input reference_conv,
                  input scan_last, output ready);
endinterface

interface ecls_out_if;
  logic                               valid;
  logic                               ready;
  logic                               found;
  logic        [ecls_pkg::IDX_W-1:0]  best_index;
  logic signed [ecls_pkg::CONV_W-1:0] new_reference;
  logic        [ecls_pkg::SQ_W-1:0]   gradient_norm;
  logic        [ecls_pkg::CODE_W-1:0] suppress_code;

  modport source (output valid, output found, output best_index, output new_reference,
                  output gradient_norm, output suppress_code, input ready);
  modport sink   (input valid, input found, input best_index, input new_reference,
                  input gradient_norm, input suppress_code, output ready);
endinterface

`default_nettype wire

// File: rtl/ecls_cfg.sv
// APB-style configuration registers: mode, threshold and the two ratio bounds.
// Depends on ecls_pkg.
`default_nettype none

module ecls_cfg (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [ecls_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [ecls_pkg::DATA_W-1:0]   pwdata,
  output logic      [ecls_pkg::DATA_W-1:0]   prdata,
  output logic                               pready,
  output ecls_pkg::ecls_cfg_t                cfg
);
  import ecls_pkg::*;

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.contrast_mode        <= 1'b1;
      cfg.likelihood_threshold <= '0;
      cfg.ratio_below          <= MU1_W'(128);
      cfg.ratio_above          <= MU2_W'(128);
    end else if (wr_en) begin
      unique case (paddr[3:2])
        REG_MODE:      cfg.contrast_mode        <= pwdata[0];
        REG_THRESHOLD: cfg.likelihood_threshold <= pwdata[THR_W-1:0];
        REG_MU1:       cfg.ratio_below          <= pwdata[MU1_W-1:0];
        REG_MU2:       cfg.ratio_above          <= pwdata[MU2_W-1:0];
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (paddr[3:2])
      REG_MODE:      prdata = DATA_W'(cfg.contrast_mode);
      REG_THRESHOLD: prdata = DATA_W'(cfg.likelihood_threshold);
      REG_MU1:       prdata = DATA_W'(cfg.ratio_below);
      REG_MU2:       prdata = DATA_W'(cfg.ratio_above);
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/ecls_score.sv
// Candidate test: threshold, contrast ratio window and best-so-far compare.
// Purely combinational; depends on ecls_pkg.
`default_nettype none

module ecls_score (
  input  wire ecls_pkg::ecls_cfg_t                 cfg,
  input  wire logic signed [ecls_pkg::CONV_W-1:0]  conv,
  input  wire logic signed [ecls_pkg::CONV_W-1:0]  ref_conv,
  input  wire logic                                in_range,
  input  wire logic                                best_found,
  input  wire logic        [ecls_pkg::SCORE_W-1:0] best_score,
  output ecls_pkg::ecls_decision_t           dec
);
  import ecls_pkg::*;

  logic signed [CONV_W:0]    sum;
  logic signed [CONV_W:0]    diff;
  logic        [THR_W-1:0]   lik_c;
  logic        [SCORE_W-1:0] lik_p;
  logic        [SCORE_W-1:0] closeness;
  logic        [CONV_W-1:0]  mag;
  logic signed [9:0]         lo_f;
  logic signed [11:0]        hi_f;
  logic signed [33:0]        lo;
  logic signed [35:0]        hi;
  logic signed [35:0]        n;
  logic                      in_band;
  logic                      ref_pos;
  logic                      ref_nz;
  logic                      pass_c;
  logic signed [2*CONV_W-1:0] sq;

  always_comb begin
    sum   = (CONV_W+1)'(conv) + (CONV_W+1)'(ref_conv);
    diff  = (CONV_W+1)'(ref_conv) - (CONV_W+1)'(conv);
    lik_c = sum[CONV_W] ? THR_W'(-sum) : THR_W'(sum);
    closeness = diff[CONV_W] ? SCORE_W'(-diff) : SCORE_W'(diff);
    mag   = conv[CONV_W-1] ? CONV_W'(-conv) : CONV_W'(conv);
    lik_p = {mag, 1'b0};

    // ratio window by cross-multiplication: 256*c against (256-mu1)*r, (256+mu2)*r
    lo_f = 10'sd256 - $signed({2'b00, cfg.ratio_below});
    hi_f = 12'sd256 + $signed({2'b00, cfg.ratio_above});
    lo   = lo_f * ref_conv;
    hi   = hi_f * ref_conv;
    n    = 36'(conv) <<< 8;
    ref_nz  = ref_conv != '0;
    ref_pos = ref_nz & ~ref_conv[CONV_W-1];
    if (ref_pos) begin
      in_band = (n > 36'(lo)) && (n < hi);
    end else begin
      in_band = (n < 36'(lo)) && (n > hi);
    end

    pass_c = lik_c > cfg.likelihood_threshold;
    sq     = conv * conv;

    dec.square   = sq[SQ_W-1:0];
    dec.nz_value = conv != '0;
    dec.nz_write = in_range & cfg.contrast_mode & pass_c;
    if (cfg.contrast_mode) begin
      dec.score = closeness;
      dec.take  = in_range & pass_c & ref_nz & in_band &
                  (~best_found | (closeness < best_score));
    end else begin
      dec.score = lik_p;
      dec.take  = in_range & (lik_p > best_score) &
                  (lik_p > SCORE_W'(cfg.likelihood_threshold));
    end
  end

endmodule

`default_nettype wire

// File: rtl/edge_candidate_likelihood_select.sv
// Top level: input register, scan state, candidate test and result register.
// Depends on ecls_pkg, ecls_if, ecls_cfg and ecls_score.
//
//   channel | dir | handshake        | word
//   cand    | in  | valid/ready      | conv_value, reference_conv, scan_last
//   result  | out | valid/ready      | found, best_index, new_reference,
//           |     |                  | gradient_norm, suppress_code
//   apb     | in  | psel/penable     | paddr, pwdata -> prdata, pready always high
//
// One candidate word per cycle unless the input side is held. A word is tested against
// the running best while it sits in the input register; when a last word leaves it,
// the result word is registered and shows on the result port from the result register.
// Reset is synchronous; it restores the register defaults and empties the scan.
// Only a last word waiting on a full result register holds the input side.
`default_nettype none

module edge_candidate_likelihood_select #(
  parameter int MAX_CANDIDATES = 65
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  ecls_in_if.sink                          cand,
  ecls_out_if.source                       result,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [ecls_pkg::ADDR_W-1:0] paddr,
  input  wire logic [ecls_pkg::DATA_W-1:0] pwdata,
  output logic      [ecls_pkg::DATA_W-1:0] prdata,
  output logic                             pready
);
  import ecls_pkg::*;

  localparam int CNT_W = $clog2(MAX_CANDIDATES + 1);

  ecls_cfg_t      cfg;
  ecls_decision_t dec;

  // input register
  logic                     s1_valid;
  logic signed [CONV_W-1:0] s1_conv;
  logic signed [CONV_W-1:0] s1_ref;
  logic                     s1_last;

  // scan state
  logic        [CNT_W-1:0]   count;
  logic signed [CONV_W-1:0]  lat_ref;
  logic                      best_found;
  logic        [CNT_W-1:0]   best_pos;
  logic signed [CONV_W-1:0]  best_conv;
  logic        [SQ_W-1:0]    best_sq;
  logic        [SCORE_W-1:0] best_score;
  logic                      last_nz;

  logic                      res_valid;
  logic                      s1_go;
  logic                      advance;
  logic                      in_range;
  logic signed [CONV_W-1:0]  ref_eff;
  logic                      found_next;
  logic                      last_nz_next;

  ecls_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign ref_eff  = (count == '0) ? s1_ref : lat_ref;
  assign in_range = count < CNT_W'(MAX_CANDIDATES);

  ecls_score u_score (
    .cfg        (cfg),
    .conv       (s1_conv),
    .ref_conv   (ref_eff),
    .in_range   (in_range),
    .best_found (best_found),
    .best_score (best_score),
    .dec        (dec)
  );

  // a last word needs a free result slot; any other word moves on at once
  assign s1_go      = ~s1_last | ~res_valid | result.ready;
  assign advance    = s1_valid & s1_go;
  assign cand.ready = ~s1_valid | s1_go;

  assign found_next   = dec.take | best_found;
  assign last_nz_next = dec.nz_write ? dec.nz_value : last_nz;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (cand.valid & cand.ready) begin
      s1_valid <= 1'b1;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cand.valid & cand.ready) begin
      s1_conv <= cand.conv_value;
      s1_ref  <= cand.reference_conv;
      s1_last <= cand.scan_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      best_found <= 1'b0;
      best_score <= '0;
      last_nz    <= 1'b0;
    end else if (advance) begin
      if (s1_last) begin
        count      <= '0;
        best_found <= 1'b0;
        best_score <= '0;
        last_nz    <= 1'b0;
      end else begin
        if (in_range) begin
          count <= count + CNT_W'(1);
        end
        best_found <= found_next;
        last_nz    <= last_nz_next;
        if (dec.take) begin
          best_score <= dec.score;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      lat_ref <= ref_eff;
      if (dec.take) begin
        best_pos  <= count;
        best_conv <= s1_conv;
        best_sq   <= dec.square;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance & s1_last) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance & s1_last) begin
      result.found <= found_next;
      if (dec.take) begin
        result.best_index    <= IDX_W'(count);
        result.new_reference <= s1_conv;
        result.gradient_norm <= dec.square;
        result.suppress_code <= SUP_NONE;
      end else if (best_found) begin
        result.best_index    <= IDX_W'(best_pos);
        result.new_reference <= best_conv;
        result.gradient_norm <= best_sq;
        result.suppress_code <= SUP_NONE;
      end else begin
        result.best_index    <= '0;
        result.new_reference <= ref_eff;
        result.gradient_norm <= '0;
        result.suppress_code <= last_nz_next ? SUP_CONTRAST : SUP_THRESHOLD;
      end
    end
  end

  assign result.valid = res_valid;

endmodule

`default_nettype wire

// File: rtl/ecls_check.sv
// Port-level checks on the result channel of the block, bound to the top level.
// Depends on ecls_pkg for the suppression codes.
`default_nettype none

module ecls_check (
  input wire logic                        clk,
  input wire logic                        rst,
  input wire logic                        out_valid,
  input wire logic                        out_ready,
  input wire logic                        found,
  input wire logic [ecls_pkg::IDX_W-1:0]  best_index,
  input wire logic [ecls_pkg::SQ_W-1:0]   gradient_norm,
  input wire logic [ecls_pkg::CODE_W-1:0] suppress_code
);
  import ecls_pkg::*;

  // a stalled result word stays offered
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  // a selection carries no suppression
  a_found_code: assert property (@(posedge clk) disable iff (rst)
    out_valid && found |-> suppress_code == SUP_NONE)
    else $error("suppression code with a selected candidate");

  // no selection: zero index and gradient, and a real suppression reason
  a_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && !found |-> best_index == '0 && gradient_norm == '0 &&
      (suppress_code == SUP_CONTRAST || suppress_code == SUP_THRESHOLD))
    else $error("empty result word not clean");

  // a selected square stays inside the 24-bit signed range squared
  a_norm: assert property (@(posedge clk) disable iff (rst)
    out_valid && found |-> gradient_norm <= (SQ_W'(1) << (SQ_W - 1)))
    else $error("gradient norm out of range");

endmodule

bind edge_candidate_likelihood_select ecls_check u_ecls_check (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (result.valid),
  .out_ready     (result.ready),
  .found         (result.found),
  .best_index    (result.best_index),
  .gradient_norm (result.gradient_norm),
  .suppress_code (result.suppress_code)
);

`default_nettype wire
